@@ design/cpv_pkg.sv @@
`default_nettype none
package cpv_pkg;
  typedef enum logic [2:0] {
    SEC_HEADER = 3'd0, SEC_NAME = 3'd1, SEC_PAD = 3'd2, SEC_FADER = 3'd3,
    SEC_ENC = 3'd4, SEC_LED = 3'd5, SEC_COLOUR = 3'd6, SEC_BLOB = 3'd7
  } section_t;

  typedef enum logic [1:0] {
    CFG_AGNOSTIC = 2'd0, CFG_ENC_MODE = 2'd1, CFG_LED_TYPE = 2'd2, CFG_LED_SEM = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] agnostic;
    logic [7:0] enc_mode;
    logic [7:0] led_type;
    logic [7:0] led_sem;
  } cfg_t;

  localparam logic [15:0] NO_REF_OFFSET = 16'hFFFF;
  localparam logic [7:0]  VALUE_MAX     = 8'd127;
  localparam logic [7:0]  CHANNEL_MAX   = 8'd15;
  localparam logic [7:0]  HDR_CHANNEL_MAX = 8'd16;
  localparam logic [3:0]  HDR_LAST      = 4'd12;
  localparam logic [7:0]  VERSION_ONE   = 8'd1;
  localparam logic [7:0]  VERSION_TWO   = 8'd2;

  function automatic logic [7:0] magic_byte(input logic [1:0] p);
    case (p)
      2'd0: magic_byte = 8'h4D;
      2'd1: magic_byte = 8'h44;
      2'd2: magic_byte = 8'h46;
      default: magic_byte = 8'h31;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ design/cpv_stream_if.sv @@
`default_nettype none
interface cpv_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/cpv_cfg_regs.sv @@
`default_nettype none
module cpv_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [7:0]   cfg_data,
  output cpv_pkg::cfg_t     cfg
);
  import cpv_pkg::*;
  cfg_t cfg_r;
  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{agnostic: 8'd255, enc_mode: 8'd2, led_type: 8'd1, led_sem: 8'd2};
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_AGNOSTIC: cfg_r.agnostic <= cfg_data;
        CFG_ENC_MODE: cfg_r.enc_mode <= cfg_data;
        CFG_LED_TYPE: cfg_r.led_type <= cfg_data;
        CFG_LED_SEM:  cfg_r.led_sem  <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/cpv_parser.sv @@
`default_nettype none
module cpv_parser #(
  parameter int MAX_PADS = 16, MAX_FADERS = 16, MAX_ENCODERS = 16,
  parameter int MAX_LED_RANGES = 16, MAX_COLORS = 32, MAX_NAME_BLOB = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  b,
  input  wire logic        fin,
  input  cpv_pkg::cfg_t    cfg,
  output logic             ok,
  output logic [10:0]      blob_len
);
  import cpv_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic        v2_r, v2_nxt;
  logic [7:0]  cnt_r [6], cnt_nxt [6];
  section_t    sec_r, sec_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  rec_r, rec_nxt;
  logic [7:0]  hold_r [8], hold_nxt [8];
  logic [16:0] maxref_r, maxref_nxt;
  logic [16:0] lastz_r, lastz_nxt;
  logic        fail_r, fail_nxt;

  logic [7:0]  r [9];
  logic [3:0]  size;
  logic [7:0]  cur_cnt;
  logic        rec_ok;
  logic [16:0] off;
  logic        ref_en;
  logic [2:0]  next_sec;
  logic [16:0] win_end;

  function automatic logic rng_ok(input logic [7:0] lo, input logic [7:0] hi);
    rng_ok = lo <= VALUE_MAX && hi <= VALUE_MAX && lo <= hi;
  endfunction

  function automatic logic ch_ok(input logic [7:0] lo, input logic [7:0] hi,
                                 input logic [7:0] a);
    if (lo == a && hi == a) ch_ok = 1'b1;
    else if (lo == a || hi == a) ch_ok = 1'b0;
    else ch_ok = lo <= hi && hi <= CHANNEL_MAX;
  endfunction

  always_comb begin
    case (sec_r)
      SEC_PAD:   size = v2_r ? 4'd4 : 4'd2;
      SEC_FADER: size = v2_r ? 4'd6 : 4'd4;
      SEC_LED:   size = v2_r ? 4'd9 : 4'd7;
      default:   size = 4'd3;
    endcase
    cur_cnt = cnt_r[3'(sec_r) - 3'd1];
    for (int i = 0; i < 8; i++) r[i] = hold_r[i];
    r[8] = b;
    r[size - 4'd1] = b;
    off = 17'd0;
    ref_en = 1'b0;
    win_end = 17'({r[5], r[4]}) + 17'(r[6]);
    case (sec_r)
      SEC_PAD: rec_ok = rng_ok(r[0], r[1]) && (!v2_r || ch_ok(r[2], r[3], cfg.agnostic));
      SEC_FADER: begin
        off = 17'({r[3], r[2]});
        ref_en = {r[3], r[2]} != NO_REF_OFFSET;
        rec_ok = rng_ok(r[0], r[1]) && (!v2_r || ch_ok(r[4], r[5], cfg.agnostic));
      end
      SEC_ENC: rec_ok = rng_ok(r[0], r[1]) && r[2] <= cfg.enc_mode;
      SEC_LED: rec_ok = r[0] <= cfg.led_type && rng_ok(r[1], r[2]) &&
                        r[3] <= cfg.led_sem && win_end <= 17'(cnt_r[5]) &&
                        (!v2_r || ch_ok(r[7], r[8], cfg.agnostic));
      default: begin
        off = 17'({r[1], r[0]});
        ref_en = 1'b1;
        rec_ok = r[2] <= VALUE_MAX && {r[1], r[0]} != NO_REF_OFFSET;
      end
    endcase
  end

  // first non-empty section after the current one (or after the header)
  always_comb begin
    next_sec = 3'(SEC_BLOB);
    for (int t = 6; t >= 1; t--) begin
      if (t > int'(sec_r) && cnt_r[t-1] != 8'd0) next_sec = 3'(t);
    end
  end

  always_comb begin
    logic adv;
    logic [7:0] hdr_c [6];
    adv = 1'b0;
    pos_nxt = pos_r; v2_nxt = v2_r; cnt_nxt = cnt_r; sec_nxt = sec_r;
    idx_nxt = idx_r; rec_nxt = rec_r; hold_nxt = hold_r;
    maxref_nxt = maxref_r; lastz_nxt = lastz_r; fail_nxt = fail_r;
    hdr_c = cnt_r;
    if (!fail_r) begin
      case (sec_r)
        SEC_HEADER: begin
          if (pos_r < 16'd4) begin
            if (b != magic_byte(pos_r[1:0])) fail_nxt = 1'b1;
          end else if (pos_r == 16'd4) begin
            if (b != VERSION_ONE && b != VERSION_TWO) fail_nxt = 1'b1;
            v2_nxt = b == VERSION_TWO;
          end else if (pos_r == 16'd5) begin
            if (b != 8'd0) fail_nxt = 1'b1;
          end else if (pos_r == 16'd6) begin
            if (b > HDR_CHANNEL_MAX) fail_nxt = 1'b1;
          end else begin
            hdr_c[3'(pos_r - 16'd7)] = cnt_r[3'(pos_r - 16'd7)] | b;
            cnt_nxt = hdr_c;
          end
          if (pos_r < 16'(HDR_LAST)) pos_nxt = pos_r + 16'd1;
          else if (32'(hdr_c[1]) > 32'(MAX_PADS) || 32'(hdr_c[2]) > 32'(MAX_FADERS) ||
                   32'(hdr_c[3]) > 32'(MAX_ENCODERS) ||
                   32'(hdr_c[4]) > 32'(MAX_LED_RANGES) ||
                   32'(hdr_c[5]) > 32'(MAX_COLORS)) fail_nxt = 1'b1;
          else adv = 1'b1;
        end
        SEC_BLOB: begin
          if (32'(pos_r) >= 32'(MAX_NAME_BLOB)) fail_nxt = 1'b1;
          else begin
            if (b == 8'd0) lastz_nxt = 17'(pos_r);
            pos_nxt = pos_r + 16'd1;
          end
        end
        SEC_NAME: begin
          rec_nxt = rec_r + 8'd1;
          if (rec_nxt >= cur_cnt) adv = 1'b1;
        end
        default: begin
          if (idx_r + 4'd1 < size) begin
            hold_nxt[idx_r[2:0]] = b;
            idx_nxt = idx_r + 4'd1;
          end else if (!rec_ok) fail_nxt = 1'b1;
          else begin
            if (ref_en && off + 17'd1 > maxref_r) maxref_nxt = off + 17'd1;
            idx_nxt = 4'd0;
            for (int i = 0; i < 8; i++) hold_nxt[i] = 8'd0;
            rec_nxt = rec_r + 8'd1;
            if (rec_nxt >= cur_cnt) adv = 1'b1;
          end
        end
      endcase
      if (adv) begin
        rec_nxt = 8'd0; idx_nxt = 4'd0;
        for (int i = 0; i < 8; i++) hold_nxt[i] = 8'd0;
        if (sec_r == SEC_HEADER) begin
          sec_nxt = SEC_BLOB;
          for (int t = 6; t >= 1; t--) if (hdr_c[t-1] != 8'd0) sec_nxt = section_t'(3'(t));
        end else sec_nxt = section_t'(next_sec);
        if (sec_nxt == SEC_BLOB) pos_nxt = 16'd0;
      end
    end
  end

  logic fin_ok;
  always_comb begin
    fin_ok = !fail_nxt && sec_nxt == SEC_BLOB;
    if (fin_ok && maxref_nxt != 17'd0)
      if (lastz_nxt[16] || lastz_nxt < maxref_nxt - 17'd1) fin_ok = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && fin)) begin
      pos_r <= '0; v2_r <= 1'b0; sec_r <= SEC_HEADER; idx_r <= '0; rec_r <= '0;
      maxref_r <= '0; lastz_r <= 17'h10000; fail_r <= 1'b0;
      for (int i = 0; i < 6; i++) cnt_r[i] <= '0;
      for (int i = 0; i < 8; i++) hold_r[i] <= '0;
    end else if (take) begin
      pos_r <= pos_nxt; v2_r <= v2_nxt; cnt_r <= cnt_nxt; sec_r <= sec_nxt;
      idx_r <= idx_nxt; rec_r <= rec_nxt; hold_r <= hold_nxt;
      maxref_r <= maxref_nxt; lastz_r <= lastz_nxt; fail_r <= fail_nxt;
    end
  end

  assign ok = fin_ok;
  assign blob_len = fin_ok ? pos_nxt[10:0] : 11'd0;
endmodule
`default_nettype wire

@@ design/controller_profile_validator.sv @@
// Controller profile validator.
// in_ channel: one image byte per transaction (image_byte, final_byte).
// out_ channel: one verdict (profile_ok, blob_length) per image, emitted for
// the transaction that carries final_byte.
// cfg_ channel: register writes (index 0..3), always ready; write only when
// the block is idle.
// Throughput: one byte per cycle while in_ready is high. The byte is checked by
// the parser in the cycle it is accepted; the verdict sits in the output
// register from the next cycle on.
// When the receiver stalls with a verdict held, further bytes are still taken
// until another final byte arrives; in_ready drops only then.
// Reset (synchronous, rst_n low) returns the parser to the header, clears the
// output valid flag and restores register defaults. After each final byte the
// parser returns to its reset state by itself.
`default_nettype none
module controller_profile_validator #(
  parameter int MAX_PADS = 16,
  parameter int MAX_FADERS = 16,
  parameter int MAX_ENCODERS = 16,
  parameter int MAX_LED_RANGES = 16,
  parameter int MAX_COLORS = 32,
  parameter int MAX_NAME_BLOB = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_image_byte,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_profile_ok,
  output logic [10:0]      out_blob_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import cpv_pkg::*;

  cfg_t        cfg;
  logic        take, ok;
  logic [10:0] blen;
  logic        ov_r;
  logic        ok_r;
  logic [10:0] len_r;

  cpv_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );

  cpv_parser #(
    .MAX_PADS(MAX_PADS), .MAX_FADERS(MAX_FADERS), .MAX_ENCODERS(MAX_ENCODERS),
    .MAX_LED_RANGES(MAX_LED_RANGES), .MAX_COLORS(MAX_COLORS),
    .MAX_NAME_BLOB(MAX_NAME_BLOB)
  ) u_parser (
    .clk, .rst_n, .take, .b(in_image_byte), .fin(in_final_byte), .cfg,
    .ok, .blob_len(blen)
  );

  // hold back only a final byte while the previous verdict waits
  assign in_ready = !ov_r || out_ready || !in_final_byte;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (take && in_final_byte) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_final_byte) begin
      ok_r  <= ok;
      len_r <= blen;
    end
  end

  assign out_valid = ov_r;
  assign out_profile_ok = ok_r;
  assign out_blob_length = len_r;
endmodule
`default_nettype wire

@@ design/cpv_checker.sv @@
`default_nettype none
module cpv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_final_byte,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_profile_ok,
  input wire logic [10:0] out_blob_length
);
  a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_profile_ok |-> out_blob_length == 11'd0)
    else $error("failed verdict with non-zero blob length");
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final_byte |=> out_valid)
    else $error("final byte produced no verdict");
  a_no_spur: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready && in_final_byte) |=> !out_valid)
    else $error("verdict without final byte");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_profile_ok)
      && $stable(out_blob_length))
    else $error("stalled verdict changed");
endmodule

bind controller_profile_validator cpv_checker u_cpv_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_final_byte, .out_valid, .out_ready,
  .out_profile_ok, .out_blob_length
);
`default_nettype wire

@@ dv/controller_profile_validator_tb.sv @@
`default_nettype none
module controller_profile_validator_tb;
  import cpv_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  cpv_stream_if #(.W(9))  in_if ();
  cpv_stream_if #(.W(12)) out_if ();
  cpv_stream_if #(.W(10)) cfg_if ();

  controller_profile_validator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .in_image_byte(in_if.data[7:0]), .in_final_byte(in_if.data[8]),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_profile_ok(out_if.data[11]), .out_blob_length(out_if.data[10:0]),
    .cfg_valid(cfg_if.valid), .cfg_ready(cfg_if.ready),
    .cfg_index(cfg_if.data[9:8]), .cfg_data(cfg_if.data[7:0])
  );

  localparam int unsigned NO_ZERO = 32'h10000;
  localparam int MAX_PADS_TB = 16;

  typedef struct packed {
    logic        ok;
    logic [10:0] blob_len;
  } verdict_t;

  // pending bytes {final, byte} and verdicts still owed by the block
  logic [8:0] byte_q[$];
  verdict_t   verdicts_due[$];
  logic [7:0] img[$];
  int         errors = 0;

  cfg_t       regs;

  // parser state
  section_t    sec;
  int unsigned pos;
  bit          v2;
  logic [7:0]  cnt[1:6];
  int unsigned ridx, rcount;
  logic [7:0]  rec[0:8];
  int unsigned max_ref, last_zero;
  bit          failed;

  function automatic void clear_parser();
    sec = SEC_HEADER;
    pos = 0;
    v2 = 1'b0;
    for (int i = 1; i <= 6; i++) cnt[i] = '0;
    ridx = 0;
    rcount = 0;
    for (int i = 0; i < 9; i++) rec[i] = '0;
    max_ref = 0;
    last_zero = NO_ZERO;
    failed = 1'b0;
  endfunction

  function automatic int unsigned rec_size(section_t s);
    case (s)
      SEC_PAD:   return v2 ? 4 : 2;
      SEC_FADER: return v2 ? 6 : 4;
      SEC_LED:   return v2 ? 9 : 7;
      default:   return 3;
    endcase
  endfunction

  function automatic void next_section(int from_s);
    rcount = 0;
    ridx = 0;
    for (int i = 0; i < 9; i++) rec[i] = '0;
    for (int t = from_s + 1; t <= 6; t++) begin
      if (cnt[t] != 0) begin
        sec = section_t'(t);
        return;
      end
    end
    sec = SEC_BLOB;
    pos = 0;
  endfunction

  function automatic bit range_good(logic [7:0] lo, logic [7:0] hi);
    return lo <= VALUE_MAX && hi <= VALUE_MAX && lo <= hi;
  endfunction

  function automatic bit chans_good(logic [7:0] lo, logic [7:0] hi);
    if (lo == regs.agnostic && hi == regs.agnostic) return 1'b1;
    if (lo == regs.agnostic || hi == regs.agnostic) return 1'b0;
    return lo <= hi && hi <= CHANNEL_MAX;
  endfunction

  function automatic void note_ref(int unsigned off);
    if (off + 1 > max_ref) max_ref = off + 1;
  endfunction

  function automatic bit record_good(section_t s);
    int unsigned off;
    case (s)
      SEC_PAD: begin
        if (!range_good(rec[0], rec[1])) return 1'b0;
        return !v2 || chans_good(rec[2], rec[3]);
      end
      SEC_FADER: begin
        if (!range_good(rec[0], rec[1])) return 1'b0;
        off = {rec[3], rec[2]};
        if (off != NO_REF_OFFSET) note_ref(off);
        return !v2 || chans_good(rec[4], rec[5]);
      end
      SEC_ENC: return range_good(rec[0], rec[1]) && rec[2] <= regs.enc_mode;
      SEC_LED: begin
        if (rec[0] > regs.led_type) return 1'b0;
        if (!range_good(rec[1], rec[2])) return 1'b0;
        if (rec[3] > regs.led_sem) return 1'b0;
        off = {rec[5], rec[4]};
        if (off + rec[6] > cnt[6]) return 1'b0;
        return !v2 || chans_good(rec[7], rec[8]);
      end
      default: begin
        off = {rec[1], rec[0]};
        if (rec[2] > VALUE_MAX) return 1'b0;
        if (off == NO_REF_OFFSET) return 1'b0;
        note_ref(off);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    int unsigned sz;
    case (sec)
      SEC_HEADER: begin
        if (pos < 4) begin
          if (b != magic_byte(pos[1:0])) failed = 1'b1;
        end else if (pos == 4) begin
          if (b != VERSION_ONE && b != VERSION_TWO) failed = 1'b1;
          v2 = (b == VERSION_TWO);
        end else if (pos == 5) begin
          if (b != 0) failed = 1'b1;
        end else if (pos == 6) begin
          if (b > HDR_CHANNEL_MAX) failed = 1'b1;
        end else begin
          cnt[pos - 6] = b;
        end
        if (pos < HDR_LAST) begin
          pos++;
        end else if (cnt[2] > MAX_PADS_TB || cnt[3] > 16 || cnt[4] > 16 ||
                     cnt[5] > 16 || cnt[6] > 32) begin
          failed = 1'b1;
        end else begin
          next_section(0);
        end
      end
      SEC_BLOB: begin
        if (pos >= 1024) begin
          failed = 1'b1;
        end else begin
          if (b == 0) last_zero = pos;
          pos++;
        end
      end
      SEC_NAME: begin
        rcount++;
        if (rcount >= cnt[1]) next_section(1);
      end
      default: begin
        sz = rec_size(sec);
        if (ridx + 1 < sz) begin
          rec[ridx] = b;
          ridx++;
        end else begin
          rec[sz - 1] = b;
          if (!record_good(sec)) begin
            failed = 1'b1;
          end else begin
            ridx = 0;
            for (int i = 0; i < 9; i++) rec[i] = '0;
            rcount++;
            if (rcount >= cnt[sec]) next_section(int'(sec));
          end
        end
      end
    endcase
  endfunction

  function automatic void take_transaction(logic [7:0] b, logic last);
    verdict_t v;
    bit ok;
    if (!failed) parse_byte(b);
    if (!last) return;
    ok = !failed && sec == SEC_BLOB;
    if (ok && max_ref != 0 && (last_zero == NO_ZERO || last_zero < max_ref - 1)) ok = 1'b0;
    v.ok = ok;
    v.blob_len = ok ? pos[10:0] : 11'd0;
    verdicts_due.push_back(v);
    clear_parser();
  endfunction

  task automatic report(string what, int unsigned expv, int unsigned got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, expv, got);
    errors++;
  endtask

  // checker: retire verdicts first, then absorb bytes and register writes
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (verdicts_due.size() == 0) begin
          report("verdicts pending", 0, 1);
        end else begin
          e = verdicts_due.pop_front();
          if (out_if.data[11] !== e.ok) report("profile_ok", e.ok, out_if.data[11]);
          if (out_if.data[10:0] !== e.blob_len)
            report("blob_length", e.blob_len, out_if.data[10:0]);
        end
      end
      if (in_if.valid && in_if.ready) take_transaction(in_if.data[7:0], in_if.data[8]);
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_t'(cfg_if.data[9:8]))
          CFG_AGNOSTIC: regs.agnostic = cfg_if.data[7:0];
          CFG_ENC_MODE: regs.enc_mode = cfg_if.data[7:0];
          CFG_LED_TYPE: regs.led_type = cfg_if.data[7:0];
          CFG_LED_SEM:  regs.led_sem  = cfg_if.data[7:0];
        endcase
      end
    end
  end

  function automatic int unsigned draw_wait();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
  endfunction

  // byte driver
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
      send_gap <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_if.data <= byte_q.pop_front();
        in_if.valid <= 1'b1;
        send_gap <= draw_wait();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // verdict receiver with random back-pressure
  int unsigned hold_cnt = 0;
  always @(posedge clk) begin
    int unsigned s;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_cnt <= 0;
    end else if (out_if.valid && out_if.ready) begin
      s = draw_wait();
      hold_cnt <= s;
      out_if.ready <= (s == 0);
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= (hold_cnt == 1);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (byte_q.size() != 0 || in_if.valid || verdicts_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= {idx, val};
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_regs(logic [7:0] a, logic [7:0] m, logic [7:0] t, logic [7:0] s);
    wait_idle();
    write_reg(CFG_AGNOSTIC, a);
    write_reg(CFG_ENC_MODE, m);
    write_reg(CFG_LED_TYPE, t);
    write_reg(CFG_LED_SEM, s);
  endtask

  task automatic header(int ver, int nn, int np, int nf, int ne, int nl, int nc);
    img.delete();
    img.push_back(8'h4D); img.push_back(8'h44); img.push_back(8'h46); img.push_back(8'h31);
    img.push_back(ver); img.push_back(0); img.push_back($urandom_range(0, 16));
    img.push_back(nn); img.push_back(np); img.push_back(nf);
    img.push_back(ne); img.push_back(nl); img.push_back(nc);
  endtask

  task automatic push_range();
    int lo;
    lo = $urandom_range(0, 127);
    img.push_back(lo);
    img.push_back($urandom_range(lo, 127));
  endtask

  task automatic push_chans(bit ver2);
    int lo, hi;
    if (!ver2) return;
    lo = $urandom_range(0, 15);
    hi = $urandom_range(lo, 15);
    if ($urandom_range(0, 3) == 0 || lo == regs.agnostic || hi == regs.agnostic) begin
      lo = regs.agnostic;
      hi = regs.agnostic;
    end
    img.push_back(lo);
    img.push_back(hi);
  endtask

  task automatic push_u16(int unsigned v);
    img.push_back(v[7:0]);
    img.push_back(v[15:8]);
  endtask

  // well-formed image with random content
  task automatic build_image();
    int ver, nn, np, nf, ne, nl, nc, blen, wo;
    ver = $urandom_range(1, 2);
    nn = $urandom_range(0, 3); np = $urandom_range(0, 3); nf = $urandom_range(0, 3);
    ne = $urandom_range(0, 3); nl = $urandom_range(0, 3); nc = $urandom_range(0, 4);
    blen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
    if (blen == 0) nc = 0;
    header(ver, nn, np, nf, ne, nl, nc);
    repeat (nn) img.push_back($urandom_range(0, 255));
    repeat (np) begin
      push_range();
      push_chans(ver == 2);
    end
    repeat (nf) begin
      push_range();
      push_u16((blen == 0 || $urandom_range(0, 2) == 0) ? 16'hFFFF : $urandom_range(0, blen - 1));
      push_chans(ver == 2);
    end
    repeat (ne) begin
      push_range();
      img.push_back($urandom_range(0, regs.enc_mode));
    end
    repeat (nl) begin
      img.push_back($urandom_range(0, regs.led_type));
      push_range();
      img.push_back($urandom_range(0, regs.led_sem));
      wo = $urandom_range(0, nc);
      push_u16(wo);
      img.push_back($urandom_range(0, nc - wo));
      push_chans(ver == 2);
    end
    repeat (nc) begin
      push_u16($urandom_range(0, blen - 1));
      img.push_back($urandom_range(0, 127));
    end
    if (blen != 0) begin
      repeat (blen - 1) img.push_back($urandom_range(0, 255));
      img.push_back(0);
    end
  endtask

  task automatic send_image(int upto);
    for (int i = 0; i <= upto; i++) byte_q.push_back({i == upto, img[i]});
  endtask

  task automatic send_all();
    send_image(img.size() - 1);
  endtask

  task automatic random_images(int nbytes);
    int sent, mode, k;
    sent = 0;
    while (sent < nbytes) begin
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
        img.delete();
        if ($urandom_range(0, 1)) header($urandom_range(0, 3), 0, 0, 0, 0, 0, 0);
        repeat ($urandom_range(1, 25)) img.push_back($urandom_range(0, 255));
      end else begin
        build_image();
        if (mode == 7) begin
          k = $urandom_range(0, img.size() - 1);
          img[k] = $urandom_range(0, 255);
        end
      end
      k = (mode == 8) ? $urandom_range(0, img.size() - 1) : img.size() - 1;
      send_image(k);
      sent += k + 1;
      // hold off now and then until the block has answered everything
      if ($urandom_range(0, 15) == 0) wait_idle();
    end
  endtask

  initial begin
    clear_parser();
    regs = '{agnostic: 8'd255, enc_mode: 8'd2, led_type: 8'd1, led_sem: 8'd2};
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // header alone, and cut short
    header(1, 0, 0, 0, 0, 0, 0); send_all();
    header(2, 0, 0, 0, 0, 0, 0); send_image(5);
    // broken header fields, plus the channel byte at its limit of 16
    header(1, 0, 0, 0, 0, 0, 0); img[0] = 8'h4E; send_all();
    header(3, 0, 0, 0, 0, 0, 0); send_all();
    header(1, 0, 0, 0, 0, 0, 0); img[5] = 8'h01; send_all();
    header(1, 0, 0, 0, 0, 0, 0); img[6] = 8'd17; send_all();
    header(1, 0, 0, 0, 0, 0, 0); img[6] = 8'd16; send_all();
    header(1, 0, 17, 0, 0, 0, 0); send_all();
    header(1, 0, 0, 0, 0, 0, 33); send_all();
    // colour offset that can never be inside the blob
    header(1, 0, 0, 0, 0, 0, 1); push_u16(16'hFFFF); img.push_back(5); img.push_back(0);
    send_all();
    // offset past the last zero byte
    header(1, 0, 0, 0, 0, 0, 1); push_u16(3); img.push_back(127);
    img.push_back(0); img.push_back(1); img.push_back(2); img.push_back(3); img.push_back(9);
    send_all();
    // extreme record values, version two
    header(2, 1, 1, 1, 1, 1, 1); img.push_back(8'hFF);
    img.push_back(0); img.push_back(127); img.push_back(255); img.push_back(255);
    img.push_back(127); img.push_back(127); push_u16(16'hFFFF); img.push_back(0);
    img.push_back(15);
    img.push_back(0); img.push_back(127); img.push_back(2);
    img.push_back(1); img.push_back(0); img.push_back(127); img.push_back(2);
    push_u16(0); img.push_back(1); img.push_back(255); img.push_back(255);
    push_u16(0); img.push_back(127); img.push_back(0);
    send_all();
    // range out of order and over 127
    header(1, 0, 1, 0, 0, 0, 0); img.push_back(9); img.push_back(3); send_all();
    header(1, 0, 0, 0, 1, 0, 0); img.push_back(0); img.push_back(128); img.push_back(0);
    send_all();
    // largest blob, then one byte too many
    header(1, 0, 0, 0, 0, 0, 0); repeat (1024) img.push_back($urandom_range(0, 255));
    send_all();
    header(1, 0, 0, 0, 0, 0, 0); repeat (1025) img.push_back($urandom_range(0, 255));
    send_all();

    random_images(100);
    set_regs(8'd0, 8'd0, 8'd0, 8'd0);
    random_images(100);
    set_regs(8'd255, 8'd255, 8'd255, 8'd255);
    random_images(100);
    set_regs(8'd7, $urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5));
    random_images(100);

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("controller_profile_validator_tb: clean");
    end else begin
      $display("controller_profile_validator_tb: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("controller_profile_validator_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
design/cpv_pkg.sv
design/cpv_stream_if.sv
design/cpv_cfg_regs.sv
design/cpv_parser.sv
design/controller_profile_validator.sv
design/cpv_checker.sv
dv/controller_profile_validator_tb.sv
